@@ hdl/lscl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor calibrate and locate package
// Shared constants, phase codes and the lane control type.
// ----------------------------------------------------------------------------
package lscl_pkg;

  localparam int unsigned SensorsDef  = 6;
  localparam int unsigned TimeBitsDef = 16;
  localparam int unsigned FullScale   = 1000;
  localparam int unsigned ValBits     = 10;
  localparam int unsigned PosBits     = 13;
  localparam int unsigned ThrResetVal = 64;

  localparam logic [2:0] PhNotCal = 3'd0;
  localparam logic [2:0] PhStart  = 3'd1;
  localparam logic [2:0] PhCalib  = 3'd2;
  localparam logic [2:0] PhStop   = 3'd3;
  localparam logic [2:0] PhReady  = 3'd4;

  localparam logic [0:0] CfgThreshold = 1'd0;
  localparam logic [0:0] CfgWhiteLine = 1'd1;

  // Control from the sequencer to every lane.
  typedef struct packed {
    logic start;
    logic reset_span;
    logic track;
  } lane_ctrl_t;

endpackage

@@ hdl/lscl_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor calibrate and locate stream interface
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
interface lscl_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/lscl_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor calibrate and locate divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lscl_div #(
  parameter int unsigned NumBits = 32,
  parameter int unsigned DenBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               done_o,
  output logic [NumBits-1:0] quot_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quot_q, quot_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DenBits:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenBits-1:0], quot_q[NumBits-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

@@ hdl/lscl_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor calibrate and locate lane
// Per-sensor min/max tracking and scaling with its own divider.
// ----------------------------------------------------------------------------
module lscl_lane #(
  parameter int unsigned TimeBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lscl_pkg::lane_ctrl_t ctrl_i,
  input  logic [TimeBits-1:0]  raw_i,
  output logic                 done_o,
  output logic [9:0]           value_o
);
  import lscl_pkg::*;

  localparam int unsigned NumBits = TimeBits + ValBits;

  logic [TimeBits-1:0] min_q, min_d, max_q, max_d;
  logic [TimeBits-1:0] span;
  logic [NumBits-1:0]  num, quot;
  logic                zero_span, below;
  logic                zero_q, below_q;
  logic                div_done;
  logic                div_start;

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (ctrl_i.reset_span) begin
      min_d = '1;
      max_d = '0;
    end else if (ctrl_i.track) begin
      if (raw_i < min_q) min_d = raw_i;
      if (raw_i > max_q) max_d = raw_i;
    end
  end

  // min <= max holds after calibration; span is non-negative.
  assign span      = max_q - min_q;
  assign zero_span = (max_q == min_q);
  assign below     = (raw_i <= min_q);
  assign num       = NumBits'(raw_i - min_q) * NumBits'(FullScale);
  assign div_start = ctrl_i.start && !zero_span && !below;

  lscl_div #(.NumBits(NumBits), .DenBits(TimeBits)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num),
    .den_i  (span),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    max_q <= max_d;
    if (ctrl_i.start) begin
      zero_q  <= zero_span || below;
      below_q <= below;
    end
  end

  logic short_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) short_q <= 1'b0;
    else short_q <= ctrl_i.start && (zero_span || below);
  end

  assign done_o  = div_done || short_q;
  assign value_o = (zero_q || below_q) ? '0 :
                   (quot > NumBits'(FullScale)) ? ValBits'(FullScale) : quot[ValBits-1:0];
endmodule

@@ hdl/lscl_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor calibrate and locate merge
// Weighted average of the lane values, one lane a cycle, then one division.
// ----------------------------------------------------------------------------
module lscl_merge #(
  parameter int unsigned Sensors = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [Sensors-1:0][9:0] values_i,
  input  logic [9:0]              threshold_i,
  input  logic                    white_i,
  output logic                    done_o,
  output logic [12:0]             pos_o
);
  import lscl_pkg::*;

  localparam int unsigned IdxBits = $clog2(Sensors + 1);
  localparam int unsigned TotBits = $clog2(Sensors * FullScale + 1);
  localparam int unsigned WBits   = $clog2(Sensors * Sensors * FullScale * FullScale + 1);

  logic [IdxBits-1:0] idx_q, idx_d;
  logic [IdxBits-1:0] lane_idx;
  logic               acc_q, acc_d;
  logic [TotBits-1:0] tot_q, tot_d;
  logic [WBits-1:0]   wsum_q, wsum_d;
  logic [IdxBits+ValBits-1:0] weight_q, weight_d;
  logic [9:0]         v, w;
  logic               div_start, div_done, empty_q;
  logic [WBits-1:0]   quot;

  assign lane_idx = idx_q;

  always_comb begin
    idx_d     = idx_q;
    acc_d     = acc_q;
    tot_d     = tot_q;
    wsum_d    = wsum_q;
    weight_d  = weight_q;
    div_start = 1'b0;
    v = values_i[lane_idx[$clog2(Sensors)-1:0]];
    w = white_i ? ValBits'(FullScale) - v : v;
    if (start_i) begin
      idx_d    = '0;
      acc_d    = 1'b1;
      tot_d    = '0;
      wsum_d   = '0;
      weight_d = (IdxBits + ValBits)'(FullScale);
    end else if (acc_q) begin
      if (w > threshold_i) begin
        tot_d  = tot_q + TotBits'(w);
        wsum_d = wsum_q + WBits'(w) * WBits'(weight_q);
      end
      weight_d = weight_q + (IdxBits + ValBits)'(FullScale);
      idx_d    = idx_q + 1'b1;
      if (idx_q == IdxBits'(Sensors - 1)) begin
        acc_d     = 1'b0;
        div_start = 1'b1;
      end
    end
  end

  lscl_div #(.NumBits(WBits), .DenBits(TotBits)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (wsum_d),
    .den_i  (tot_d),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      acc_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tot_q    <= tot_d;
    wsum_q   <= wsum_d;
    weight_q <= weight_d;
    if (div_start) empty_q <= (tot_d == '0);
  end

  assign done_o = div_done;
  assign pos_o  = empty_q ? '0 : quot[PosBits-1:0];
endmodule

@@ hdl/line_sensor_calibrate_and_locate_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor calibrate and locate
// Five-phase calibration sequencer, per-sensor scaling lanes and a merging
// stage that forms the weighted line position.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake     Contents
//  in_if     sink       valid/ready   raw times of all sensors, start_stop
//  out_if    source     valid/ready   phase, line_position, calibrated values
//  cfg       write      cfg_we_i      noise_threshold (0), line color (1)
//
// An item in the ready phase passes through the lane dividers, all sensors
// side by side, then through the accumulation and the position divider.
// Items in other phases give their result in the cycle after acceptance.
// One item is in flight at a time; the output register holds a result while
// the output is stalled, and a new item is accepted when the sequencer is
// idle and the output register is empty or read in the same cycle. Reset
// clears phase, calibrated values, position and the output register; min/max
// start undefined.
// ----------------------------------------------------------------------------
module line_sensor_calibrate_and_locate_top #(
  parameter int unsigned Sensors  = lscl_pkg::SensorsDef,
  parameter int unsigned TimeBits = lscl_pkg::TimeBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  lscl_if.sink   in_if,
  lscl_if.source out_if,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [9:0] cfg_data_i
);
  import lscl_pkg::*;

  // Input payload: raw[Sensors*TimeBits-1:0] then start_stop on top.
  // Output payload: {phase, line_position, calibrated[Sensors-1:0]}.

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StLanes = 4'b0010,
    StMerge = 4'b0100,
    StOut   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [9:0] thr_q;
  logic       white_q;
  logic [2:0] phase_q, phase_d;
  logic [Sensors-1:0][9:0] scaled_q, scaled_d;
  logic [12:0] pos_q, pos_d;
  logic [Sensors-1:0][TimeBits-1:0] raw_q;
  logic        ev;
  logic        accept;
  logic        out_valid_q, out_valid_d;
  logic [2+PosBits+Sensors*ValBits:0] out_data_q, out_data_d;
  logic        load_out;
  lane_ctrl_t  ctrl;
  logic [Sensors-1:0] lane_done, lane_seen_q, lane_seen_d;
  logic [Sensors-1:0][9:0] lane_val;
  logic        merge_start, merge_done;
  logic [12:0] merge_pos;
  logic [Sensors-1:0][TimeBits-1:0] raw_in;
  logic        started_q, started_d;

  assign raw_in = in_if.data[Sensors*TimeBits-1:0];
  assign ev     = in_if.data[Sensors*TimeBits];
  assign in_if.ready = (state_q == StIdle) && (!out_valid_q || out_if.ready);
  assign accept = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= 10'(ThrResetVal);
      white_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgThreshold: thr_q <= cfg_data_i;
        CfgWhiteLine: white_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The lanes start once, in the first cycle of the lane state.
  always_comb begin
    ctrl.reset_span = accept && (phase_q == PhStart);
    ctrl.track      = accept && (phase_q == PhCalib);
    ctrl.start      = (state_q == StLanes) && !started_q;
  end

  genvar g;
  generate
    for (g = 0; g < Sensors; g++) begin : g_lane
      lscl_lane #(.TimeBits(TimeBits)) u_lane (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .raw_i  (ctrl.track || ctrl.reset_span ? raw_in[g] : raw_q[g]),
        .done_o (lane_done[g]),
        .value_o(lane_val[g])
      );
    end
  endgenerate

  lscl_merge #(.Sensors(Sensors)) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (merge_start),
    .values_i   (scaled_q),
    .threshold_i(thr_q),
    .white_i    (white_q),
    .done_o     (merge_done),
    .pos_o      (merge_pos)
  );

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    scaled_d    = scaled_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    load_out    = 1'b0;
    lane_seen_d = lane_seen_q;
    started_d   = started_q;
    merge_start = 1'b0;
    if (out_valid_q && out_if.ready) out_valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          case (phase_q)
            PhNotCal: begin
              if (ev) phase_d = PhStart;
              load_out = 1'b1;
            end
            PhStart: begin
              scaled_d = '0;
              phase_d = PhCalib;
              load_out = 1'b1;
            end
            PhCalib: begin
              if (ev) phase_d = PhStop;
              load_out = 1'b1;
            end
            PhStop: begin
              phase_d = PhReady;
              load_out = 1'b1;
            end
            PhReady: begin
              if (ev) phase_d = PhStart;
              lane_seen_d = '0;
              started_d = 1'b0;
              state_d = StLanes;
            end
            default: begin
              phase_d = PhNotCal;
              load_out = 1'b1;
            end
          endcase
        end
      end
      StLanes: begin
        started_d = 1'b1;
        lane_seen_d = lane_seen_q | lane_done;
        if (started_q && ((lane_seen_q | lane_done) == '1)) begin
          for (int i = 0; i < Sensors; i++) scaled_d[i] = lane_val[i];
          state_d = StMerge;
        end
      end
      StMerge: begin
        if (!started_q) begin
          merge_start = 1'b1;
          started_d = 1'b1;
        end else if (merge_done) begin
          pos_d = merge_pos;
          state_d = StOut;
        end
      end
      StOut: begin
        // Wait until the output register is free or being read.
        if (!out_valid_q || out_if.ready) begin
          load_out = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (state_q == StLanes && state_d == StMerge) started_d = 1'b0;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = {phase_d, pos_d, scaled_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= PhNotCal;
      scaled_q    <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      lane_seen_q <= '0;
      started_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      scaled_q    <= scaled_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      lane_seen_q <= lane_seen_d;
      started_q   <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) raw_q <= raw_in;
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;
endmodule
